>>> src/lkvc_pkg.sv
package lkvc_pkg;

  localparam int unsigned CAPACITY_DEF   = 8;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 4'd8;

  typedef enum logic [1:0] {
    KIND_GET    = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // what a cell loads at the end of the update cycle
  typedef enum logic [1:0] {
    MOVE_HOLD      = 2'd0,
    MOVE_FROM_PREV = 2'd1,
    MOVE_FROM_NEXT = 2'd2
  } move_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_e;

endpackage

>>> src/lru_key_value_cache_top.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------------------------
// command  | in        | start_i high, busy_o low | kind_i, lookup_key_i, write_value_i
// result   | out       | done_o, one cycle    | hit_o, read_value_o, occupancy_o
// config   | in        | cfg_we_i             | cfg_wdata_i (capacity limit)
//
// for each item, the accepting edge registers the key compare of every cell; at the end
// of the update cycle the row of cells moves and the result is registered.
// busy_o is high for the one update cycle; done_o follows in the cycle after, when a new
// item may already be accepted. the result has no back pressure.
// reset empties the store (count to zero) and sets the capacity limit to 8; cell contents
// are not reset.
module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            kind_i,
  input  logic [KEY_BITS-1:0]   lookup_key_i,
  input  logic [VALUE_BITS-1:0] write_value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output logic                  done_o,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic [CNT_W-1:0]      occupancy_o
);

  localparam int unsigned LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  state_e state_q, state_d;
  logic [CFG_W-1:0] limit_q;
  logic [CNT_W-1:0] count_q, count_d;

  kind_e                 kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [CAPACITY-1:0]   match_q;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] match_value_q;

  logic                  accept;
  logic                  update;
  logic [CAPACITY-1:0]   valid;
  logic [CAPACITY-1:0]   match_raw;
  logic [CAPACITY-1:0]   match_hit;
  logic [CAPACITY-1:0]   upto_mask;
  logic [CAPACITY-1:0]   from_mask;
  logic [VALUE_BITS-1:0] match_value;
  logic [VALUE_BITS-1:0] front_value;
  logic [LIM_W-1:0]      limit_eff;
  logic [LIM_W-1:0]      count_ext;
  logic [LIM_W-1:0]      kept;
  logic [CNT_W-1:0]      insert_count;

  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  move_e                 cell_move  [CAPACITY];

  assign accept = start_i && (state_q == ST_IDLE);
  assign update = (state_q == ST_UPDATE);
  assign busy_o = update;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      limit_q <= LIMIT_RESET;
      count_q <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_o  <= update;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // the row of cells; cell 0 is the most recent entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]   prev_key;
    logic [VALUE_BITS-1:0] prev_value;
    logic [KEY_BITS-1:0]   next_key;
    logic [VALUE_BITS-1:0] next_value;

    if (i == 0) begin : g_front
      assign prev_key   = key_q;
      assign prev_value = front_value;
    end else begin : g_mid
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_key   = cell_key[i];
      assign next_value = cell_value[i];
    end else begin : g_body
      assign next_key   = cell_key[i+1];
      assign next_value = cell_value[i+1];
    end

    lkvc_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .move_i      (cell_move[i]),
      .prev_key_i  (prev_key),
      .prev_value_i(prev_value),
      .next_key_i  (next_key),
      .next_value_i(next_value),
      .cmp_key_i   (lookup_key_i),
      .key_o       (cell_key[i]),
      .value_o     (cell_value[i]),
      .match_o     (match_raw[i])
    );

    assign valid[i]     = (CNT_W'(i) < count_q);
    assign match_hit[i] = match_raw[i] && valid[i];
    // cells at or before the hit slot, and at or after it
    assign upto_mask[i] = |match_q[CAPACITY-1:i];
    assign from_mask[i] = |match_q[i:0];
  end

  // keys are unique among valid entries, so at most one cell matches
  always_comb begin
    match_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_value = match_value | (match_hit[i] ? cell_value[i] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q        <= kind_e'(kind_i);
      key_q         <= lookup_key_i;
      value_q       <= write_value_i;
      match_q       <= match_hit;
      hit_q         <= |match_hit;
      match_value_q <= match_value;
    end
  end

  assign front_value = (kind_q == KIND_PUT) ? value_q : match_value_q;

  // put of an absent key: evict down to limit minus one, then insert at the front
  always_comb begin
    count_ext = LIM_W'(count_q);
    if (limit_q == '0) begin
      limit_eff = LIM_W'(1);
    end else if (LIM_W'(limit_q) > LIM_W'(CAPACITY)) begin
      limit_eff = LIM_W'(CAPACITY);
    end else begin
      limit_eff = LIM_W'(limit_q);
    end
    kept         = (count_ext >= limit_eff) ? (limit_eff - LIM_W'(1)) : count_ext;
    insert_count = CNT_W'(kept + LIM_W'(1));
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) cell_move[i] = MOVE_HOLD;
    if (update) begin
      unique case (kind_q)
        KIND_GET: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (hit_q && upto_mask[i]) cell_move[i] = MOVE_FROM_PREV;
          end
        end
        KIND_PUT: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!hit_q || upto_mask[i]) cell_move[i] = MOVE_FROM_PREV;
          end
          if (!hit_q) count_d = insert_count;
        end
        KIND_DELETE: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (hit_q && from_mask[i]) cell_move[i] = MOVE_FROM_NEXT;
          end
          if (hit_q) count_d = count_q - CNT_W'(1);
        end
        KIND_CLEAR: count_d = '0;
        default:    count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (update) begin
      hit_o        <= hit_q && (kind_q != KIND_CLEAR);
      read_value_o <= (hit_q && (kind_q == KIND_GET)) ? match_value_q : '0;
      occupancy_o  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |=> done_o && !busy_o)
    else $error("result strobe must follow the update cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i && !busy_o |=> busy_o)
    else $error("accepted item did not enter the update cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |-> $onehot0(match_q))
    else $error("key present in more than one cell");

endmodule

>>> src/lkvc_cell.sv
module lkvc_cell
  import lkvc_pkg::*;
#(
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  move_e                 move_i,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [VALUE_BITS-1:0] prev_value_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic [VALUE_BITS-1:0] next_value_i,
  input  logic [KEY_BITS-1:0]   cmp_key_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  match_o
);

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    case (move_i)
      MOVE_FROM_PREV: begin
        key_d   = prev_key_i;
        value_d = prev_value_i;
      end
      MOVE_FROM_NEXT: begin
        key_d   = next_key_i;
        value_d = next_value_i;
      end
      default: begin
        key_d   = key_q;
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = (key_q == cmp_key_i);

endmodule

>>> bench/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps

module lru_key_value_cache_checker
  import lkvc_pkg::*;
#(
  parameter int unsigned CAP   = CAPACITY_DEF,
  parameter int unsigned KB    = KEY_BITS_DEF,
  parameter int unsigned VB    = VALUE_BITS_DEF,
  parameter int unsigned OCC_W = $clog2(CAPACITY_DEF + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [1:0]       kind_i,
  input  logic [KB-1:0]    lookup_key_i,
  input  logic [VB-1:0]    write_value_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             done_i,
  input  logic             hit_i,
  input  logic [VB-1:0]    read_value_i,
  input  logic [OCC_W-1:0] occupancy_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               hit_count_o,
  output int               result_count_o
);

  typedef struct packed {
    logic             hit;
    logic [VB-1:0]    value;
    logic [OCC_W-1:0] occ;
  } lookup_result_t;

  // mirror of the store, slot 0 most recent
  logic [KB-1:0]    key_row   [CAP];
  logic [VB-1:0]    value_row [CAP];
  int               live_count;
  logic [CFG_W-1:0] limit_reg;

  lookup_result_t   result_q [$];
  lookup_result_t   want;
  lookup_result_t   got;

  // bring slot s to the front, pushing the more recent entries back by one
  task automatic move_to_front(input int s);
    logic [KB-1:0] k;
    logic [VB-1:0] v;
    k = key_row[s];
    v = value_row[s];
    for (int i = s; i > 0; i--) begin
      key_row[i]   = key_row[i-1];
      value_row[i] = value_row[i-1];
    end
    key_row[0]   = k;
    value_row[0] = v;
  endtask

  task automatic apply_lookup(input kind_e k, input logic [KB-1:0] key,
                              input logic [VB-1:0] v, output lookup_result_t r);
    int slot;
    int lim;
    r    = '0;
    slot = -1;
    if (k == KIND_CLEAR) begin
      live_count = 0;
    end else begin
      for (int i = 0; i < live_count; i++)
        if (slot < 0 && key_row[i] == key) slot = i;
      r.hit = (slot >= 0);
      case (k)
        KIND_GET: begin
          if (r.hit) begin
            r.value = value_row[slot];
            move_to_front(slot);
          end
        end
        KIND_PUT: begin
          if (r.hit) begin
            value_row[slot] = v;
            move_to_front(slot);
          end else begin
            lim = (limit_reg == 0) ? 1 : ((limit_reg > CAP) ? CAP : int'(limit_reg));
            // evict least recent entries until one slot is free under the limit
            if (live_count >= lim) live_count = lim - 1;
            for (int i = live_count; i > 0; i--) begin
              key_row[i]   = key_row[i-1];
              value_row[i] = value_row[i-1];
            end
            key_row[0]   = key;
            value_row[0] = v;
            live_count++;
          end
        end
        default: begin
          if (r.hit) begin
            for (int i = slot; i < live_count - 1; i++) begin
              key_row[i]   = key_row[i+1];
              value_row[i] = value_row[i+1];
            end
            live_count--;
          end
        end
      endcase
    end
    r.occ = live_count[OCC_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_count = 0;
      limit_reg  = LIMIT_RESET;
      result_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      hit_count_o    = 0;
      result_count_o = 0;
    end else begin
      if (done_i) begin
        got = '{hit: hit_i, value: read_value_i, occ: occupancy_i};
        if (result_q.size() == 0) begin
          $display("%0t: result with no item outstanding, got hit %0b value %h occupancy %0d",
                   $time, got.hit, got.value, got.occ);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          result_count_o++;
          if (got.hit) hit_count_o++;
          if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, got.hit);
            fail_count_o++;
          end
          if (got.value !== want.value) begin
            $display("%0t: read_value mismatch, expected %h, got %h",
                     $time, want.value, got.value);
            fail_count_o++;
          end
          if (got.occ !== want.occ) begin
            $display("%0t: occupancy mismatch, expected %0d, got %0d",
                     $time, want.occ, got.occ);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      if (start_i && !busy_i) begin
        apply_lookup(kind_e'(kind_i), lookup_key_i, write_value_i, want);
        result_q.push_back(want);
      end
      pending_o = result_q.size();
    end
  end

endmodule

>>> bench/tb_lru_key_value_cache_top.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  localparam int unsigned KB       = KEY_BITS_DEF;
  localparam int unsigned VB       = VALUE_BITS_DEF;
  localparam int unsigned OCC_W    = $clog2(CAPACITY_DEF + 1);
  localparam int          N_PHASES = 10;
  localparam int          PHASE_N  = 110;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [1:0]       kind_i;
  logic [KB-1:0]    lookup_key_i;
  logic [VB-1:0]    write_value_i;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             done_o;
  logic             hit_o;
  logic [VB-1:0]    read_value_o;
  logic [OCC_W-1:0] occupancy_o;

  int fail_count;
  int pending;
  int hit_count;
  int result_count;
  int items_sent;
  int limit_writes;

  logic [KB-1:0] key_pool [12];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lru_key_value_cache_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .occupancy_o   (occupancy_o)
  );

  lru_key_value_cache_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .kind_i         (kind_i),
    .lookup_key_i   (lookup_key_i),
    .write_value_i  (write_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_i         (done_o),
    .hit_i          (hit_o),
    .read_value_i   (read_value_o),
    .occupancy_i    (occupancy_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .hit_count_o    (hit_count),
    .result_count_o (result_count)
  );

  // present one item and hold it until the block takes it
  task automatic issue(input kind_e k, input logic [KB-1:0] key, input logic [VB-1:0] v);
    @(negedge clk_i);
    start_i       <= 1'b1;
    kind_i        <= k;
    lookup_key_i  <= key;
    write_value_i <= v;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] lim);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [KB-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 11)];
    return KB'($urandom_range(0, (1 << KB) - 1));
  endfunction

  function automatic kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_GET;
    if (r < 80) return KIND_PUT;
    if (r < 95) return KIND_DELETE;
    return KIND_CLEAR;
  endfunction

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int burst_left;
    logic [CFG_W-1:0] lim;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    kind_i        = KIND_GET;
    lookup_key_i  = '0;
    write_value_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    items_sent    = 0;
    limit_writes  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty store, extremes of key and value, update, eviction at full, delete, clear
    issue(KIND_GET, 16'h1234, 32'h0);
    issue(KIND_DELETE, 16'h1234, 32'h0);
    issue(KIND_CLEAR, 16'h0, 32'hffff_ffff);
    issue(KIND_PUT, 16'h0000, 32'h0000_0000);
    issue(KIND_PUT, 16'hffff, 32'hffff_ffff);
    issue(KIND_GET, 16'h0000, 32'hdead_beef);
    issue(KIND_GET, 16'hffff, 32'h0);
    issue(KIND_PUT, 16'h0000, 32'ha5a5_a5a5);
    for (int i = 1; i <= 6; i++) issue(KIND_PUT, KB'(i), VB'(32'h1000 * i));
    issue(KIND_PUT, 16'h0007, 32'h5a5a_5a5a);
    issue(KIND_GET, 16'hffff, 32'h0);
    issue(KIND_GET, 16'h0000, 32'h0);
    issue(KIND_DELETE, 16'h0003, 32'h0);
    issue(KIND_DELETE, 16'h0003, 32'h0);
    issue(KIND_GET, 16'h0007, 32'h0);
    issue(KIND_CLEAR, 16'h0007, 32'h0);
    issue(KIND_GET, 16'h0000, 32'h0);
    // zero limit behaves as one
    write_limit(4'd0);
    issue(KIND_PUT, 16'h0010, 32'h1);
    issue(KIND_PUT, 16'h0011, 32'h2);
    issue(KIND_GET, 16'h0010, 32'h0);
    // oversize limit behaves as full capacity, then lower it under occupancy
    write_limit(4'd15);
    for (int i = 0; i < 5; i++) issue(KIND_PUT, KB'(16'h20 + i), VB'($urandom()));
    write_limit(4'd2);
    issue(KIND_GET, 16'h0020, 32'h0);
    issue(KIND_DELETE, 16'h0021, 32'h0);
    issue(KIND_PUT, 16'h0030, 32'h3);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       lim = 4'd1;
        1:       lim = 4'd8;
        2:       lim = 4'd15;
        3:       lim = 4'd0;
        default: lim = CFG_W'($urandom_range(0, 15));
      endcase
      write_limit(lim);
      foreach (key_pool[i]) key_pool[i] = KB'($urandom_range(0, (1 << KB) - 1));
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_N; n++) begin
        if (ph == 5 && n == PHASE_N / 2) wait_drained();
        issue(pick_kind(), pick_key(), VB'($urandom()));
        burst_left--;
        // odd phases run back to back with no gaps, but for the drain halfway through phase 5
        if (burst_left == 0) begin
          if (ph % 2 == 0) idle_cycles($urandom_range(0, 6));
          burst_left = $urandom_range(1, 24);
        end
      end
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    $display("sent %0d items (get, put, delete, clear) under %0d capacity limit settings",
             items_sent, limit_writes);
    $display("checked %0d results, %0d of them hits", result_count, hit_count);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache_top.sv
bench/lru_key_value_cache_checker.sv
bench/tb_lru_key_value_cache_top.sv
